// ===== design/hcs_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the carrier smoothing block.
// No dependencies; imported by every other file of the block.
package hcs_pkg;

    localparam int RANGE_W = 48;
    localparam int COUNT_W = 16;
    localparam int VAR_W   = 32;
    localparam int KEY_W   = 11;

    // shared arithmetic unit
    localparam int OPA_W  = 51;
    localparam int OPB_W  = 19;
    localparam int ACC_W  = 72;
    localparam int DIV_W  = 17;
    localparam int STEP_W = 5;

    localparam logic [DIV_W-1:0]          WEIGHT_ONE  = 17'h10000;
    localparam logic [OPB_W-1:0]          CARRIER_Q32 = 19'd429497;
    localparam logic signed [RANGE_W-1:0] RANGE_MAX   = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [RANGE_W-1:0] RANGE_MIN   = 48'sh8000_0000_0000;
    localparam logic [COUNT_W-1:0]        COUNT_MAX   = 16'hFFFF;
    localparam logic [VAR_W-1:0]          VAR_MAX     = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [7:0]                sat_number;
        logic [2:0]                sat_system;
        logic signed [RANGE_W-1:0] code_range;
        logic signed [RANGE_W-1:0] carrier_range;
        logic [VAR_W-1:0]          obs_variance;
        logic                      epoch_last;
    } in_t;

    typedef struct packed {
        logic signed [RANGE_W-1:0] smoothed_range;
        logic [COUNT_W-1:0]        smooth_count;
        logic [VAR_W-1:0]          smoothed_variance;
        logic                      arc_restarted;
    } out_t;

    typedef struct packed {
        logic [KEY_W-1:0]          key;
        logic signed [RANGE_W-1:0] smoothed;
        logic [COUNT_W-1:0]        count;
        logic [VAR_W-1:0]          variance;
        logic signed [RANGE_W-1:0] carrier;
        logic [VAR_W-1:0]          obs_var;
    } entry_t;

    typedef enum logic {
        OP_MUL,
        OP_DIV
    } op_t;

    typedef struct packed {
        logic start;
        op_t  op;
        logic keep;   // accumulate onto the previous product
    } unit_req_t;

endpackage

// ===== design/hcs_table.sv =====
`timescale 1ns / 1ps
// Two-bank satellite table: one write port, one registered read port.
// Depends on hcs_pkg for the entry type.
module hcs_table
    import hcs_pkg::*;
#(
    parameter int ADDR_W = 7
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  entry_t            wdata,
    input  logic [ADDR_W-1:0] raddr,
    output entry_t            rdata
);

    entry_t mem [2**ADDR_W];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== design/hcs_unit.sv =====
`timescale 1ns / 1ps
// Shared iterative unit: shift-add multiply-accumulate (one multiplier bit
// per cycle) and restoring divide (one quotient bit per cycle). Uses hcs_pkg.
module hcs_unit
    import hcs_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  unit_req_t               req,
    input  logic signed [OPA_W-1:0] opa,
    input  logic [OPB_W-1:0]        opb,
    output logic                    done,
    output logic signed [ACC_W-1:0] acc
);

    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    op_t                     op_reg, op_next;
    logic [STEP_W-1:0]       step_reg, step_next;
    logic signed [ACC_W-1:0] mcand_reg, mcand_next;
    logic [OPB_W-1:0]        mplier_reg, mplier_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic [COUNT_W-1:0]      rem_reg, rem_next;

    logic [DIV_W-1:0] rem_ext;
    logic [DIV_W-1:0] rem_sub;
    logic             qbit;
    logic             last;

    always_comb
    begin
        busy_next   = busy_reg;
        done_next   = 1'b0;
        op_next     = op_reg;
        step_next   = step_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        acc_next    = acc_reg;
        rem_next    = rem_reg;

        rem_ext = {rem_reg, mplier_reg[DIV_W-1]};
        rem_sub = rem_ext - {1'b0, mcand_reg[COUNT_W-1:0]};
        qbit    = rem_ext >= {1'b0, mcand_reg[COUNT_W-1:0]};
        last    = (op_reg == OP_MUL) ? (step_reg == STEP_W'(OPB_W - 1))
                                     : (step_reg == STEP_W'(DIV_W - 1));

        if (req.start)
        begin
            busy_next = 1'b1;
            op_next   = req.op;
            step_next = '0;
            rem_next  = '0;
            case (req.op)
                OP_MUL:
                begin
                    mcand_next  = ACC_W'(opa);
                    mplier_next = opb;
                    if (!req.keep)
                    begin
                        acc_next = '0;
                    end
                end
                OP_DIV:
                begin
                    // dividend walks out of mplier MSB-first, divisor sits in mcand
                    mcand_next  = $signed(ACC_W'(opb[COUNT_W-1:0]));
                    mplier_next = OPB_W'(opa[DIV_W-1:0]);
                    acc_next    = '0;
                end
                default: ;
            endcase
        end
        else if (busy_reg)
        begin
            case (op_reg)
                OP_MUL:
                begin
                    if (mplier_reg[0])
                    begin
                        acc_next = acc_reg + mcand_reg;
                    end
                    mcand_next  = mcand_reg <<< 1;
                    mplier_next = mplier_reg >> 1;
                end
                OP_DIV:
                begin
                    rem_next    = qbit ? rem_sub[COUNT_W-1:0] : rem_ext[COUNT_W-1:0];
                    acc_next    = $signed({acc_reg[ACC_W-2:0], qbit});
                    mplier_next = mplier_reg << 1;
                end
                default: ;
            endcase
            step_next = step_reg + STEP_W'(1);
            if (last)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= OP_MUL;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            op_reg   <= op_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        acc_reg    <= acc_next;
        rem_reg    <= rem_next;
    end

    assign done = done_reg;
    assign acc  = acc_reg;

endmodule

// ===== design/hatch_carrier_smoothing_top.sv =====
`timescale 1ns / 1ps
// Hatch-filter carrier smoothing top: sequencer, key search, result register.
// Depends on hcs_pkg, hcs_table and hcs_unit.
//
// Usage:
//   Input channel in_valid/in_stall/in_data carries one satellite observation
//   per transfer; output channel out_valid/out_stall/out_data returns exactly
//   one result per observation, in order. cfg_we/cfg_data write smooth_mode
//   (0 Hatch averaging, 1 raw code range); write it only while idle.
//   One observation at a time: in_stall stays high from the transfer until
//   the result is loaded into the output register.
//   The search reads one table entry per cycle from the previous epoch
//   bank until the first match or the previous epoch's entry count. A
//   continued arc adds the 1/N divide (skipped in raw mode) and seven
//   multiplies on the shared shift-add unit.
//   The next observation is taken while the previous result still waits.
//   If the receiver stalls, the result holds in the output register and a
//   finished item waits before its result is loaded.
//   Reset clears entry counts, bank select, smooth_mode and the output
//   valid; table contents are not cleared and are never used unwritten.
module hatch_carrier_smoothing_top
    import hcs_pkg::*;
#(
    parameter int MAX_SATS = 64
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  in_t  in_data,
    output logic out_valid,
    input  logic out_stall,
    output out_t out_data,
    input  logic cfg_we,
    input  logic cfg_data
);

    localparam int IDX_W  = (MAX_SATS > 1) ? $clog2(MAX_SATS) : 1;
    localparam int CNT_W  = $clog2(MAX_SATS + 1);
    localparam int ADDR_W = IDX_W + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_SCAN,
        S_PRED,
        S_GO,
        S_WAIT,
        S_FIN
    } state_t;

    typedef enum logic [2:0] {
        ST_DIV,
        ST_RNG,
        ST_WA2,
        ST_WB2,
        ST_T1,
        ST_T2,
        ST_V1,
        ST_V2
    } step_t;

    state_t                    state_reg;
    step_t                     step_reg;
    in_t                       in_reg;
    logic                      mode_reg;
    logic                      bank_reg;
    logic [CNT_W-1:0]          prev_cnt_reg;
    logic [CNT_W-1:0]          cur_cnt_reg;
    logic [IDX_W-1:0]          scan_idx_reg;
    logic                      hit_found_reg;
    entry_t                    hit_reg;
    logic [COUNT_W-1:0]        cnt_reg;
    logic signed [RANGE_W-1:0] pred_reg;
    logic [DIV_W-1:0]          wa_reg;
    logic [DIV_W-1:0]          wa2_reg;
    logic [DIV_W-1:0]          wb2_reg;
    logic [OPB_W-1:0]          t1_reg;
    logic [OPB_W-1:0]          t2_reg;
    logic signed [OPA_W-1:0]   rnd_reg;
    out_t                      out_reg;
    logic                      out_valid_reg;

    logic [KEY_W-1:0]        key;
    logic [CNT_W-1:0]        scan_nxt;
    logic [IDX_W-1:0]        rd_idx;
    logic [ADDR_W-1:0]       rd_addr;
    logic [ADDR_W-1:0]       wr_addr;
    entry_t                  rdata;
    entry_t                  wdata;
    logic                    out_free;
    logic                    table_full;
    logic                    tbl_we;
    logic [COUNT_W-1:0]      cnt_inc;
    logic signed [51:0]      pred_sum;
    logic signed [51:0]      rng_sum;
    logic [DIV_W-1:0]        wb;
    logic [DIV_W-1:0]        dividend;
    logic signed [OPA_W-1:0] diff;
    logic [33:0]             s_sum;
    unit_req_t               req;
    logic signed [OPA_W-1:0] opa;
    logic [OPB_W-1:0]        opb;
    logic                    unit_done;
    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] rnd16;
    logic signed [ACC_W-1:0] rnd32;
    logic [VAR_W-1:0]        var_sat;
    logic signed [RANGE_W-1:0] rng_fin;
    out_t                    res;

    function automatic logic signed [RANGE_W-1:0] sat48(input logic signed [51:0] v);
        logic signed [RANGE_W-1:0] r;
        if (v > 52'(RANGE_MAX))
        begin
            r = RANGE_MAX;
        end
        else if (v < 52'(RANGE_MIN))
        begin
            r = RANGE_MIN;
        end
        else
        begin
            r = v[RANGE_W-1:0];
        end
        return r;
    endfunction

    assign key        = {in_reg.sat_system, in_reg.sat_number};
    assign scan_nxt   = CNT_W'(scan_idx_reg) + CNT_W'(1);
    assign rd_idx     = (state_reg == S_SCAN) ? scan_nxt[IDX_W-1:0] : scan_idx_reg;
    assign rd_addr    = {bank_reg, rd_idx};
    assign wr_addr    = {~bank_reg, cur_cnt_reg[IDX_W-1:0]};
    assign out_free   = !out_valid_reg || !out_stall;
    assign table_full = (cur_cnt_reg == CNT_W'(MAX_SATS));
    assign tbl_we     = (state_reg == S_FIN) && out_free && !table_full;

    assign cnt_inc  = (hit_reg.count == COUNT_MAX) ? COUNT_MAX : hit_reg.count + COUNT_W'(1);
    assign pred_sum = 52'(hit_reg.smoothed) + 52'(in_reg.carrier_range) - 52'(hit_reg.carrier);
    assign rng_sum  = 52'(pred_reg) + 52'(rnd_reg);
    assign wb       = WEIGHT_ONE - wa_reg;
    assign dividend = WEIGHT_ONE + DIV_W'(cnt_reg >> 1);
    assign diff     = OPA_W'(in_reg.code_range) - OPA_W'(pred_reg);
    assign s_sum    = 34'(hit_reg.variance) + 34'(t1_reg) + 34'(t2_reg);

    assign rnd16 = (acc + 72'sd32768) >>> 16;
    assign rnd32 = (acc + 72'sd2147483648) >>> 32;
    assign var_sat = (rnd16 > 72'sd4294967295) ? VAR_MAX : rnd16[VAR_W-1:0];
    assign rng_fin = sat48(rng_sum);

    // operand select for the shared unit
    always_comb
    begin
        req.start = (state_reg == S_GO);
        req.op    = OP_MUL;
        req.keep  = 1'b0;
        opa       = '0;
        opb       = '0;
        case (step_reg)
            ST_DIV:
            begin
                req.op = OP_DIV;
                opa    = $signed(OPA_W'(dividend));
                opb    = OPB_W'(cnt_reg);
            end
            ST_RNG:
            begin
                opa = diff;
                opb = OPB_W'(wa_reg);
            end
            ST_WA2:
            begin
                opa = $signed(OPA_W'(wa_reg));
                opb = OPB_W'(wa_reg);
            end
            ST_WB2:
            begin
                opa = $signed(OPA_W'(wb));
                opb = OPB_W'(wb);
            end
            ST_T1:
            begin
                opa = $signed(OPA_W'(in_reg.obs_variance));
                opb = CARRIER_Q32;
            end
            ST_T2:
            begin
                opa = $signed(OPA_W'(hit_reg.obs_var));
                opb = CARRIER_Q32;
            end
            ST_V1:
            begin
                opa = $signed(OPA_W'(in_reg.obs_variance));
                opb = OPB_W'(wa2_reg);
            end
            ST_V2:
            begin
                req.keep = 1'b1;
                opa      = $signed(OPA_W'(s_sum));
                opb      = OPB_W'(wb2_reg);
            end
            default: ;
        endcase
    end

    always_comb
    begin
        wdata.key      = key;
        wdata.carrier  = in_reg.carrier_range;
        wdata.obs_var  = in_reg.obs_variance;
        if (hit_found_reg)
        begin
            res.smoothed_range    = rng_fin;
            res.smooth_count      = cnt_reg;
            res.smoothed_variance = var_sat;
            res.arc_restarted     = 1'b0;
        end
        else
        begin
            res.smoothed_range    = in_reg.code_range;
            res.smooth_count      = COUNT_W'(1);
            res.smoothed_variance = in_reg.obs_variance;
            res.arc_restarted     = 1'b1;
        end
        wdata.smoothed = res.smoothed_range;
        wdata.count    = res.smooth_count;
        wdata.variance = res.smoothed_variance;
    end

    hcs_table #(
        .ADDR_W (ADDR_W)
    ) u_table (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (wr_addr),
        .wdata (wdata),
        .raddr (rd_addr),
        .rdata (rdata)
    );

    hcs_unit u_unit (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .opa   (opa),
        .opb   (opb),
        .done  (unit_done),
        .acc   (acc)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= ST_DIV;
            in_reg        <= '0;
            mode_reg      <= 1'b0;
            bank_reg      <= 1'b0;
            prev_cnt_reg  <= '0;
            cur_cnt_reg   <= '0;
            scan_idx_reg  <= '0;
            hit_found_reg <= 1'b0;
            hit_reg       <= '0;
            cnt_reg       <= '0;
            pred_reg      <= '0;
            wa_reg        <= '0;
            wa2_reg       <= '0;
            wb2_reg       <= '0;
            t1_reg        <= '0;
            t2_reg        <= '0;
            rnd_reg       <= '0;
            out_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                mode_reg <= cfg_data;
            end
            if (state_reg == S_FIN && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        in_reg        <= in_data;
                        scan_idx_reg  <= '0;
                        hit_found_reg <= 1'b0;
                        state_reg     <= (prev_cnt_reg == '0) ? S_FIN : S_FETCH;
                    end
                end
                S_FETCH:
                begin
                    state_reg <= S_SCAN;
                end
                S_SCAN:
                begin
                    // first match in table order wins
                    if (rdata.key == key)
                    begin
                        hit_found_reg <= 1'b1;
                        hit_reg       <= rdata;
                        state_reg     <= S_PRED;
                    end
                    else if (scan_nxt == prev_cnt_reg)
                    begin
                        state_reg <= S_FIN;
                    end
                    else
                    begin
                        scan_idx_reg <= scan_nxt[IDX_W-1:0];
                    end
                end
                S_PRED:
                begin
                    cnt_reg  <= cnt_inc;
                    pred_reg <= sat48(pred_sum);
                    if (mode_reg)
                    begin
                        wa_reg   <= WEIGHT_ONE;
                        step_reg <= ST_RNG;
                    end
                    else
                    begin
                        step_reg <= ST_DIV;
                    end
                    state_reg <= S_GO;
                end
                S_GO:
                begin
                    state_reg <= S_WAIT;
                end
                S_WAIT:
                begin
                    if (unit_done)
                    begin
                        state_reg <= S_GO;
                        case (step_reg)
                            ST_DIV:
                            begin
                                wa_reg   <= acc[DIV_W-1:0];
                                step_reg <= ST_RNG;
                            end
                            ST_RNG:
                            begin
                                rnd_reg  <= rnd16[OPA_W-1:0];
                                step_reg <= ST_WA2;
                            end
                            ST_WA2:
                            begin
                                wa2_reg  <= rnd16[DIV_W-1:0];
                                step_reg <= ST_WB2;
                            end
                            ST_WB2:
                            begin
                                wb2_reg  <= rnd16[DIV_W-1:0];
                                step_reg <= ST_T1;
                            end
                            ST_T1:
                            begin
                                t1_reg   <= rnd32[OPB_W-1:0];
                                step_reg <= ST_T2;
                            end
                            ST_T2:
                            begin
                                t2_reg   <= rnd32[OPB_W-1:0];
                                step_reg <= ST_V1;
                            end
                            ST_V1:
                            begin
                                step_reg <= ST_V2;
                            end
                            ST_V2:
                            begin
                                state_reg <= S_FIN;
                            end
                            default: ;
                        endcase
                    end
                end
                S_FIN:
                begin
                    if (out_free)
                    begin
                        out_reg       <= res;
                        state_reg     <= S_IDLE;
                        if (in_reg.epoch_last)
                        begin
                            prev_cnt_reg <= table_full ? cur_cnt_reg
                                                       : cur_cnt_reg + CNT_W'(1);
                            cur_cnt_reg  <= '0;
                            bank_reg     <= ~bank_reg;
                        end
                        else if (!table_full)
                        begin
                            cur_cnt_reg <= cur_cnt_reg + CNT_W'(1);
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ===== design/hcs_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the carrier smoothing top, bound to it below.
// Depends on hcs_pkg for the payload types.
module hcs_checker
    import hcs_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_stall,
    input logic out_valid,
    input logic out_stall,
    input out_t out_data
);

    // one item in flight: a transfer in is followed by stall
    a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken again right after a transfer");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result dropped or changed");

    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.smooth_count != 16'd0)
        else $error("smoothing count is zero");

    a_restart_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.arc_restarted |-> out_data.smooth_count == 16'd1)
        else $error("restarted arc without count one");

    a_smoothed_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.arc_restarted |-> out_data.smooth_count != 16'd1)
        else $error("continued arc with count one");

endmodule

bind hatch_carrier_smoothing_top hcs_checker u_hcs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

// ===== tb/hcs_checker.sv =====
`timescale 1ns / 1ps
// Checker for the carrier smoothing block: watches both channels, predicts
// each result from its own copy of the epoch tables and compares. Uses hcs_pkg.
module hcs_scoreboard
    import hcs_pkg::*;
#(
    parameter int MAX_SATS = 64
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  logic in_stall,
    input  in_t  in_data,
    input  logic out_valid,
    input  logic out_stall,
    input  out_t out_data,
    input  logic cfg_we,
    input  logic cfg_data,
    output int   errors,
    output int   pending
);

    entry_t      arc_bank [2][MAX_SATS];
    int          prev_cnt;
    int          cur_cnt;
    bit          prev_sel;
    bit          raw_mode;
    out_t        expected_q[$];

    assign pending = expected_q.size();

    function automatic logic [63:0] carrier_noise(input logic [31:0] v);
        logic [63:0] p;
        p = 64'(v) * 64'(CARRIER_Q32) + 64'h8000_0000;
        return p >> 32;
    endfunction

    function automatic logic signed [RANGE_W-1:0] clip48(input logic signed [63:0] v);
        if (v > 64'(RANGE_MAX)) return RANGE_MAX;
        if (v < 64'(RANGE_MIN)) return RANGE_MIN;
        return v[RANGE_W-1:0];
    endfunction

    function automatic out_t smooth_obs(input in_t obs);
        out_t              r;
        logic [KEY_W-1:0]  key;
        int                hit;
        entry_t            e;
        logic [31:0]       cnt;
        logic [16:0]       wa;
        logic [16:0]       wb;
        logic signed [63:0] pred;
        logic signed [63:0] diff;
        logic signed [63:0] hi;
        logic [63:0]       lo;
        logic [63:0]       wa2;
        logic [63:0]       wb2;
        logic [63:0]       s;
        logic [63:0]       q;
        key = {obs.sat_system, obs.sat_number};
        hit = -1;
        for (int i = 0; i < prev_cnt; i++)
        begin
            if (hit < 0 && arc_bank[prev_sel][i].key == key) hit = i;
        end
        if (hit < 0)
        begin
            r.smoothed_range = obs.code_range;
            r.smooth_count = 16'd1;
            r.smoothed_variance = obs.obs_variance;
            r.arc_restarted = 1'b1;
        end
        else
        begin
            e = arc_bank[prev_sel][hit];
            cnt = 32'(e.count) + 32'd1;
            if (cnt > 32'd65535) cnt = 32'd65535;
            wa = raw_mode ? WEIGHT_ONE : 17'((32'd65536 + cnt / 2) / cnt);
            wb = WEIGHT_ONE - wa;
            pred = clip48(64'(e.smoothed) + 64'(obs.carrier_range) - 64'(e.carrier));
            diff = 64'(obs.code_range) - pred;
            lo = 64'(diff[15:0]);
            hi = diff >>> 16;
            r.smoothed_range = clip48(pred + hi * $signed({47'd0, wa})
                                      + $signed((lo * wa + 64'd32768) >> 16));
            r.smooth_count = cnt[15:0];
            wa2 = (64'(wa) * wa + 64'd32768) >> 16;
            wb2 = (64'(wb) * wb + 64'd32768) >> 16;
            s = 64'(e.variance) + carrier_noise(obs.obs_variance) + carrier_noise(e.obs_var);
            q = (64'(obs.obs_variance) * wa2 + s * wb2 + 64'd32768) >> 16;
            r.smoothed_variance = (q > 64'(VAR_MAX)) ? VAR_MAX : q[31:0];
            r.arc_restarted = 1'b0;
        end
        if (cur_cnt < MAX_SATS)
        begin
            arc_bank[!prev_sel][cur_cnt] = '{key, r.smoothed_range, r.smooth_count,
                r.smoothed_variance, obs.carrier_range, obs.obs_variance};
            cur_cnt++;
        end
        if (obs.epoch_last)
        begin
            prev_cnt = cur_cnt;
            cur_cnt = 0;
            prev_sel = !prev_sel;
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_t want;
        if (!rst_n)
        begin
            prev_cnt = 0;
            cur_cnt = 0;
            prev_sel = 0;
            raw_mode = 0;
            errors = 0;
            expected_q.delete();
        end
        else
        begin
            if (cfg_we) raw_mode = cfg_data;
            if (in_valid && !in_stall) expected_q.push_back(smooth_obs(in_data));
            if (out_valid && !out_stall)
            begin
                if (expected_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result %h", $time, out_data);
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (out_data.smoothed_range !== want.smoothed_range)
                    begin
                        errors++;
                        $display("%0t: range exp %h got %h", $time,
                                 want.smoothed_range, out_data.smoothed_range);
                    end
                    if (out_data.smooth_count !== want.smooth_count)
                    begin
                        errors++;
                        $display("%0t: count exp %0d got %0d", $time,
                                 want.smooth_count, out_data.smooth_count);
                    end
                    if (out_data.smoothed_variance !== want.smoothed_variance)
                    begin
                        errors++;
                        $display("%0t: variance exp %h got %h", $time,
                                 want.smoothed_variance, out_data.smoothed_variance);
                    end
                    if (out_data.arc_restarted !== want.arc_restarted)
                    begin
                        errors++;
                        $display("%0t: restart exp %b got %b", $time,
                                 want.arc_restarted, out_data.arc_restarted);
                    end
                end
            end
        end
    end

endmodule

// ===== tb/tb_hatch_carrier_smoothing_top.sv =====
`timescale 1ns / 1ps
// Stimulus and verdict for the carrier smoothing block: epochs of satellite
// observations, mode changes while idle. Depends on hcs_pkg and hcs_scoreboard.
module tb_hatch_carrier_smoothing_top;
    import hcs_pkg::*;

    localparam int STALL_LIMIT = 5000;
    localparam bit MODE_HATCH = 1'b0;
    localparam bit MODE_RAW   = 1'b1;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    in_t  in_data;
    logic out_valid;
    logic out_stall;
    out_t out_data;
    logic cfg_we;
    logic cfg_data;
    int   errors;
    int   pending;
    int   quiet_cycles;

    // per-satellite running carrier so arcs stay plausible
    logic signed [RANGE_W-1:0] sat_carrier [256];

    hatch_carrier_smoothing_top dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_data(cfg_data)
    );

    hcs_scoreboard chk (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_data(cfg_data),
        .errors(errors), .pending(pending)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // watchdog on accepted transfers
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // receiver: random stall lengths, some runs with none
    initial
    begin
        int gap;
        out_stall = 1'b1;
        @(posedge rst_n);
        forever
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
            repeat (gap) @(posedge clk);
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            out_stall <= 1'b1;
        end
    end

    task automatic send_obs(input logic [7:0] num, input logic [2:0] sys,
                            input logic signed [RANGE_W-1:0] code,
                            input logic signed [RANGE_W-1:0] carr,
                            input logic [31:0] ovar, input logic last);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
        repeat (gap) @(posedge clk);
        in_data <= '{num, sys, code, carr, ovar, last};
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic drain_and_set(input bit mode);
        while (pending != 0) @(posedge clk);
        repeat (400) @(posedge clk);
        cfg_data <= mode;
        cfg_we <= 1'b1;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic signed [RANGE_W-1:0] rand_range();
        case ($urandom_range(0, 5))
            0: return RANGE_MAX;
            1: return RANGE_MIN;
            2: return RANGE_W'({$urandom, $urandom} >> 16);
            default: return RANGE_W'(48'sd1_000_000_000 + $signed(20'($urandom)));
        endcase
    endfunction

    // one epoch over a pool of satellites with random content
    task automatic send_epoch(input int nsat, input bit wild);
        logic [7:0] num;
        logic [2:0] sys;
        logic signed [RANGE_W-1:0] code;
        logic [31:0] ovar;
        for (int k = 0; k < nsat; k++)
        begin
            num = 8'($urandom_range(0, 11));
            sys = 3'($urandom_range(0, 2));
            if (wild)
            begin
                num = 8'($urandom);
                sys = 3'($urandom);
            end
            sat_carrier[num] = sat_carrier[num] + $signed(24'($urandom));
            code = sat_carrier[num] + $signed(20'($urandom));
            ovar = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 1 << 20);
            if ($urandom_range(0, 15) == 0) code = rand_range();
            send_obs(num, sys, code,
                     ($urandom_range(0, 15) == 0) ? rand_range() : sat_carrier[num],
                     ovar, k == nsat - 1);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_we = 1'b0;
        cfg_data = 1'b0;
        foreach (sat_carrier[i]) sat_carrier[i] = 48'sd1_000_000_000;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, restart, continuation, duplicates, overflow
        send_obs(8'd0, 3'd0, RANGE_MAX, RANGE_MAX, 32'hFFFF_FFFF, 1'b0);
        send_obs(8'd255, 3'd7, RANGE_MIN, RANGE_MIN, 32'd0, 1'b0);
        send_obs(8'd5, 3'd1, 48'sd100, 48'sd200, 32'd65536, 1'b0);
        send_obs(8'd5, 3'd1, 48'sd900, 48'sd50, 32'd1, 1'b1);
        send_obs(8'd0, 3'd0, RANGE_MIN, RANGE_MAX, 32'hFFFF_FFFF, 1'b0);
        send_obs(8'd255, 3'd7, RANGE_MAX, RANGE_MAX, 32'hFFFF_FFFF, 1'b0);
        send_obs(8'd5, 3'd1, 48'sd300, 48'sd400, 32'd7, 1'b1);
        send_obs(8'd0, 3'd0, RANGE_MAX, RANGE_MIN, 32'hFFFF_FFFF, 1'b1);
        send_obs(8'd0, 3'd0, 48'sh5555_5555_5555, 48'shAAAA_AAAA_AAAA, 32'h5555_5555, 1'b1);
        // table full: 70 observations in one epoch, then look up
        for (int k = 0; k < 70; k++)
            send_obs(8'(k), 3'(k), 48'sd1000, 48'sd1000, 32'd100, k == 69);
        send_obs(8'd63, 3'd7, 48'sd1000, 48'sd1000, 32'd100, 1'b0);
        send_obs(8'd66, 3'd2, 48'sd1000, 48'sd1000, 32'd100, 1'b1);

        drain_and_set(MODE_RAW);
        send_obs(8'd66, 3'd2, 48'sd2000, 48'sd1500, 32'd100, 1'b1);
        send_obs(8'd66, 3'd2, 48'sd2000, 48'sd1500, 32'd100, 1'b1);

        for (int ph = 0; ph < 6; ph++)
        begin
            drain_and_set(ph[0] ? MODE_RAW : MODE_HATCH);
            for (int ep = 0; ep < 16; ep++)
                send_epoch($urandom_range(1, 18), $urandom_range(0, 9) == 0);
        end

        while (pending != 0) @(posedge clk);
        repeat (400) @(posedge clk);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
